// File: sv/psp_pkg.sv
package psp_pkg;

  // Character classes decided by the front end
  typedef enum logic [2:0] {
    CC_CARET = 3'd0,
    CC_STAR  = 3'd1,
    CC_DASH  = 3'd2,
    CC_SLASH = 3'd3,
    CC_AT    = 3'd4,
    CC_FLAG  = 3'd5,
    CC_DIGIT = 3'd6,
    CC_OTHER = 3'd7
  } chr_cls_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_BAD_MOD    = 4'd1,
    ST_UNEXP_CHR  = 4'd2,
    ST_NO_NUMBER  = 4'd3,
    ST_RING_RANGE = 4'd4,
    ST_BAD_FLAG   = 4'd5,
    ST_BAD_MEMID  = 4'd6,
    ST_MEMID_CONF = 4'd7,
    ST_EMPTY_MEM  = 4'd8,
    ST_EARLY_END  = 4'd9
  } status_t;

  // Register modes
  localparam logic [2:0] MODE_ALL_NIC  = 3'd0;
  localparam logic [2:0] MODE_SW       = 3'd1;
  localparam logic [2:0] MODE_NIC_SW   = 3'd2;
  localparam logic [2:0] MODE_ONE_NIC  = 3'd3;
  localparam logic [2:0] MODE_ONE_SW   = 3'd4;

  // Decimal accumulator limits
  localparam logic [16:0] ACC_CAP     = 17'd131071;
  localparam logic [16:0] ACC_MUL_LIM = 17'((131071 - 9) / 10);

  // Classified character, front to back
  typedef struct packed {
    logic       end_mark;
    chr_cls_t   cls;
    logic [3:0] dval;
    logic [5:0] flag;
  } fe_item_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [2:0]  reg_mode;
    logic [11:0] ring_index;
    logic [5:0]  flag_bits;
    logic [15:0] mem_id;
    logic [7:0]  consumed;
  } res_t;

endpackage

// File: sv/port_register_suffix_parser_unit.sv
// Flow: a character enters the front-end queue and is parsed at its head by the
//   combinational back-end step; any result goes through the result queue to out_ ports.
// Throughput: one character per cycle while the result queue has room, set by the
//   combinational back-end parser step; two-entry queues on each side absorb stalls.
// Reset: synchronous, active low; empties both queues, returns the parser to the
//   start of a string and clears the preset memory id.
module port_register_suffix_parser_unit #(
  parameter int RING_LIMIT   = 4095,
  parameter int MAX_CONSUMED = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_preset_mem_id,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_end_mark,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [2:0]  out_reg_mode,
  output logic [11:0] out_ring_index,
  output logic [5:0]  out_flag_bits,
  output logic [15:0] out_mem_id,
  output logic [7:0]  out_consumed
);

  logic              q_valid;
  logic              q_pop;
  psp_pkg::fe_item_t q_item;
  psp_pkg::res_t     out_res;

  psp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_ch       (in_ch),
    .in_end_mark (in_end_mark),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  psp_back #(
    .RING_LIMIT   (RING_LIMIT),
    .MAX_CONSUMED (MAX_CONSUMED)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_preset_mem_id (cfg_preset_mem_id),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_res           (out_res)
  );

  assign out_status     = out_res.status;
  assign out_reg_mode   = out_res.reg_mode;
  assign out_ring_index = out_res.ring_index;
  assign out_flag_bits  = out_res.flag_bits;
  assign out_mem_id     = out_res.mem_id;
  assign out_consumed   = out_res.consumed;

`ifndef SYNTHESIS
  // back end only takes from a nonempty internal queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("internal queue popped while empty");

  // result queue comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // a result only appears after the parser took a character
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(q_pop))
    else $error("result appeared with no parser step");
`endif

endmodule

// File: sv/psp_front.sv
module psp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_ch,
  input  logic               in_end_mark,
  output logic               q_valid,
  output psp_pkg::fe_item_t  q_item,
  input  logic               q_pop
);

  psp_pkg::fe_item_t cls_item;
  psp_pkg::fe_item_t q_mem_r [2];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push;

  // Classify the incoming byte
  always_comb begin
    cls_item          = '0;
    cls_item.end_mark = in_end_mark;
    cls_item.dval     = 4'(in_ch - 8'h30);
    cls_item.cls      = psp_pkg::CC_OTHER;
    if (in_ch >= 8'h30 && in_ch <= 8'h39) begin
      cls_item.cls = psp_pkg::CC_DIGIT;
    end else begin
      unique case (in_ch)
        8'h5E: cls_item.cls = psp_pkg::CC_CARET;  // ^
        8'h2A: cls_item.cls = psp_pkg::CC_STAR;   // *
        8'h2D: cls_item.cls = psp_pkg::CC_DASH;   // -
        8'h2F: cls_item.cls = psp_pkg::CC_SLASH;  // /
        8'h40: cls_item.cls = psp_pkg::CC_AT;     // @
        8'h78: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b000001; end
        8'h7A: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b000010; end
        8'h74: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b000100; end
        8'h72: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b001000; end
        8'h52: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b010000; end
        8'h54: begin cls_item.cls = psp_pkg::CC_FLAG; cls_item.flag = 6'b100000; end
        default: cls_item.cls = psp_pkg::CC_OTHER;
      endcase
    end
  end

  // Two-entry queue toward the parser
  assign in_full = (cnt_r == 2'd2);
  assign do_push = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ q_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: sv/psp_back.sv
module psp_back #(
  parameter int RING_LIMIT   = 4095,
  parameter int MAX_CONSUMED = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_preset_mem_id,
  input  logic               q_valid,
  input  psp_pkg::fe_item_t  q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output psp_pkg::res_t      out_res
);

  localparam int PW = $clog2(MAX_CONSUMED + 2);
  localparam int CW = (PW > 8) ? PW : 8;

  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_SFXOK   = 7'b0000010,
    PH_GETNUM  = 7'b0000100,
    PH_FLAGS   = 7'b0001000,
    PH_FLAGSOK = 7'b0010000,
    PH_MEMID   = 7'b0100000,
    PH_ONESW   = 7'b1000000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [11:0]      ring_r, ring_nxt;
  logic [5:0]       flags_r, flags_nxt;
  logic [15:0]      memid_r, memid_nxt;
  logic [16:0]      acc_r, acc_nxt;
  logic             dseen_r, dseen_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             fin_r, fin_nxt;
  logic [15:0]      preset_r;

  logic             proc;
  logic             is_dig;
  logic             emit;
  logic             clear;
  logic             go;
  psp_pkg::status_t st;
  logic [PW-1:0]    cnt;
  logic [15:0]      memid_eff;
  logic [16:0]      acc_add;
  logic [PW-1:0]    pos_inc;
  logic [PW-1:0]    pos_esc;
  psp_pkg::status_t cls_st;
  logic [CW-1:0]    cnt_ext;
  logic [CW-1:0]    cnt_sat;
  psp_pkg::res_t    res;

  psp_pkg::res_t    oq_mem_r [2];
  logic             owptr_r, orptr_r;
  logic [1:0]       ocnt_r, ocnt_nxt;

  // Step handshake with both queues
  assign proc   = q_valid && (ocnt_r != 2'd2);
  assign q_pop  = proc;
  assign is_dig = (q_item.cls == psp_pkg::CC_DIGIT);

  // Memory id seen by the first step of a string is the preset
  assign memid_eff = (phase_r == PH_START) ? preset_r : memid_r;

  // Decimal accumulate, saturating
  assign acc_add = (acc_r > psp_pkg::ACC_MUL_LIM) ? psp_pkg::ACC_CAP :
                   (acc_r << 3) + (acc_r << 1) + 17'(q_item.dval);

  assign pos_inc = (pos_r <= PW'(MAX_CONSUMED)) ? pos_r + PW'(1) : pos_r;
  assign pos_esc = (pos_r != '0) ? pos_r - PW'(1) : '0;

  // Number check when a digit run closes
  always_comb begin
    cls_st = psp_pkg::ST_OK;
    if (phase_r == PH_GETNUM) begin
      if (acc_r >= 17'(RING_LIMIT)) cls_st = psp_pkg::ST_RING_RANGE;
    end else begin
      if (acc_r == 17'd0 || acc_r[16]) begin
        cls_st = psp_pkg::ST_BAD_MEMID;
      end else if (memid_eff != 16'd0 && memid_eff != acc_r[15:0]) begin
        cls_st = psp_pkg::ST_MEMID_CONF;
      end
    end
  end

  // Parser step
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    ring_nxt  = ring_r;
    flags_nxt = flags_r;
    memid_nxt = memid_eff;
    acc_nxt   = acc_r;
    dseen_nxt = dseen_r;
    pos_nxt   = pos_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    clear     = 1'b0;
    go        = 1'b0;
    st        = psp_pkg::ST_OK;
    cnt       = pos_r;

    if (fin_r) begin
      clear = q_item.end_mark;
    end else if (q_item.end_mark) begin
      if (dseen_r) begin
        st        = cls_st;
        dseen_nxt = 1'b0;
        acc_nxt   = '0;
        if (cls_st == psp_pkg::ST_OK) begin
          if (phase_r == PH_GETNUM) ring_nxt = acc_r[11:0];
          else memid_nxt = acc_r[15:0];
          phase_nxt = PH_SFXOK;
        end
      end
      if (st == psp_pkg::ST_OK) begin
        if (phase_nxt == PH_MEMID) begin
          st = psp_pkg::ST_EMPTY_MEM;
        end else if (phase_nxt == PH_GETNUM || phase_nxt == PH_FLAGS) begin
          st = psp_pkg::ST_EARLY_END;
        end
      end
      emit  = 1'b1;
      clear = 1'b1;
    end else begin
      go = 1'b1;
      // digit run: extend it, or close it and fall through
      if (dseen_r) begin
        if (is_dig) begin
          acc_nxt = acc_add;
          pos_nxt = pos_inc;
          go      = 1'b0;
        end else begin
          dseen_nxt = 1'b0;
          acc_nxt   = '0;
          if (cls_st != psp_pkg::ST_OK) begin
            st      = cls_st;
            fin_nxt = 1'b1;
            emit    = 1'b1;
            go      = 1'b0;
          end else begin
            if (phase_r == PH_GETNUM) ring_nxt = acc_r[11:0];
            else memid_nxt = acc_r[15:0];
            phase_nxt = PH_SFXOK;
          end
        end
      end

      if (go) begin
        // after '^' a digit selects one software ring
        if (phase_nxt == PH_ONESW) begin
          if (is_dig) begin
            mode_nxt  = psp_pkg::MODE_ONE_SW;
            phase_nxt = PH_GETNUM;
          end else begin
            phase_nxt = PH_SFXOK;
          end
        end

        unique case (phase_nxt)
          PH_START: begin
            pos_nxt = pos_inc;
            unique case (q_item.cls)
              psp_pkg::CC_CARET: begin
                mode_nxt  = psp_pkg::MODE_SW;
                phase_nxt = PH_ONESW;
              end
              psp_pkg::CC_STAR: begin
                mode_nxt  = psp_pkg::MODE_NIC_SW;
                phase_nxt = PH_SFXOK;
              end
              psp_pkg::CC_DASH: begin
                mode_nxt  = psp_pkg::MODE_ONE_NIC;
                phase_nxt = PH_GETNUM;
              end
              psp_pkg::CC_SLASH: phase_nxt = PH_FLAGS;
              psp_pkg::CC_AT:    phase_nxt = PH_MEMID;
              default: begin
                pos_nxt = pos_r;
                st      = psp_pkg::ST_BAD_MOD;
                fin_nxt = 1'b1;
                emit    = 1'b1;
              end
            endcase
          end
          PH_SFXOK: begin
            pos_nxt = pos_inc;
            unique case (q_item.cls)
              psp_pkg::CC_SLASH: phase_nxt = PH_FLAGS;
              psp_pkg::CC_AT:    phase_nxt = PH_MEMID;
              default: begin
                pos_nxt = pos_r;
                st      = psp_pkg::ST_UNEXP_CHR;
                fin_nxt = 1'b1;
                emit    = 1'b1;
              end
            endcase
          end
          PH_GETNUM: begin
            if (is_dig) begin
              acc_nxt   = 17'(q_item.dval);
              dseen_nxt = 1'b1;
              pos_nxt   = pos_inc;
            end else begin
              st      = psp_pkg::ST_NO_NUMBER;
              fin_nxt = 1'b1;
              emit    = 1'b1;
            end
          end
          PH_FLAGS, PH_FLAGSOK: begin
            if (q_item.cls == psp_pkg::CC_AT) begin
              phase_nxt = PH_MEMID;
              pos_nxt   = pos_inc;
            end else if (q_item.cls == psp_pkg::CC_FLAG) begin
              flags_nxt = flags_r | q_item.flag;
              phase_nxt = PH_FLAGSOK;
              pos_nxt   = pos_inc;
            end else begin
              st      = psp_pkg::ST_BAD_FLAG;
              fin_nxt = 1'b1;
              emit    = 1'b1;
            end
          end
          PH_MEMID: begin
            if (is_dig) begin
              acc_nxt   = 17'(q_item.dval);
              dseen_nxt = 1'b1;
              pos_nxt   = pos_inc;
            end else begin
              // escape to options: success, count stops at the '@'
              cnt     = pos_esc;
              fin_nxt = 1'b1;
              emit    = 1'b1;
            end
          end
          default: begin
            st      = psp_pkg::ST_UNEXP_CHR;
            fin_nxt = 1'b1;
            emit    = 1'b1;
          end
        endcase
      end
    end
  end

  // Result assembly
  assign cnt_ext = CW'(cnt);
  assign cnt_sat = (cnt_ext > CW'(MAX_CONSUMED)) ? CW'(MAX_CONSUMED) : cnt_ext;

  always_comb begin
    res          = '0;
    res.status   = st;
    res.consumed = cnt_sat[7:0];
    if (st == psp_pkg::ST_OK) begin
      res.reg_mode   = mode_nxt;
      res.ring_index = ring_nxt;
      res.flag_bits  = flags_nxt;
      res.mem_id     = memid_nxt;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      mode_r  <= psp_pkg::MODE_ALL_NIC;
      ring_r  <= '0;
      flags_r <= '0;
      memid_r <= '0;
      acc_r   <= '0;
      dseen_r <= 1'b0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
    end else if (proc) begin
      if (clear) begin
        phase_r <= PH_START;
        mode_r  <= psp_pkg::MODE_ALL_NIC;
        ring_r  <= '0;
        flags_r <= '0;
        memid_r <= '0;
        acc_r   <= '0;
        dseen_r <= 1'b0;
        pos_r   <= '0;
        fin_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        mode_r  <= mode_nxt;
        ring_r  <= ring_nxt;
        flags_r <= flags_nxt;
        memid_r <= memid_nxt;
        acc_r   <= acc_nxt;
        dseen_r <= dseen_nxt;
        pos_r   <= pos_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

  // Preset memory id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r <= '0;
    end else if (cfg_we) begin
      preset_r <= cfg_preset_mem_id;
    end
  end

  // Two-entry result queue
  assign out_empty = (ocnt_r == 2'd0);
  assign out_res   = oq_mem_r[orptr_r];
  assign ocnt_nxt  = ocnt_r + {1'b0, proc && emit} - {1'b0, out_pop && !out_empty};

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      oq_mem_r[owptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      owptr_r <= owptr_r ^ (proc && emit);
      orptr_r <= orptr_r ^ (out_pop && !out_empty);
      ocnt_r  <= ocnt_nxt;
    end
  end

endmodule

// File: verif/psp_checker.sv
// Watches both queue ports of the suffix parser, decodes every accepted
// character in its own copy of the parser and compares each popped result.
module psp_checker #(
  parameter int RING_LIMIT   = 4095,
  parameter int MAX_CONSUMED = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_preset_mem_id,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_end_mark,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [3:0]  out_status,
  input  logic [2:0]  out_reg_mode,
  input  logic [11:0] out_ring_index,
  input  logic [5:0]  out_flag_bits,
  input  logic [15:0] out_mem_id,
  input  logic [7:0]  out_consumed,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Suffix characters
  localparam logic [7:0] CH_CARET = "^";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_AT    = "@";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_Z     = "z";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_R     = "r";
  localparam logic [7:0] CH_UP_R  = "R";
  localparam logic [7:0] CH_UP_T  = "T";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  typedef enum logic [2:0] {
    PH_START,
    PH_SFX_OK,
    PH_RING_NUM,
    PH_FLAG_LIST,
    PH_FLAG_OK,
    PH_MEMID,
    PH_SW_RING
  } parse_phase_t;

  // Parser copy
  parse_phase_t phase;
  logic [2:0]   mode;
  logic [11:0]  ring;
  logic [5:0]   flags;
  logic [15:0]  memid;
  logic [15:0]  preset;
  int           accum;
  bit           in_number;
  int           nchars;
  bit           stopped;

  psp_pkg::res_t decoded_q[$];

  function automatic void restart_string();
    phase     = PH_START;
    mode      = psp_pkg::MODE_ALL_NIC;
    ring      = '0;
    flags     = '0;
    memid     = '0;
    accum     = 0;
    in_number = 1'b0;
    nchars    = 0;
    stopped   = 1'b0;
  endfunction

  function automatic void count_char();
    if (nchars <= MAX_CONSUMED) nchars++;
  endfunction

  // Queue one decoded request; error results carry only status and count
  function automatic void report(input psp_pkg::status_t st, input int cnt);
    psp_pkg::res_t r;
    int            n;
    n            = (cnt > MAX_CONSUMED) ? MAX_CONSUMED : cnt;
    r.status     = st;
    r.reg_mode   = (st == psp_pkg::ST_OK) ? mode  : '0;
    r.ring_index = (st == psp_pkg::ST_OK) ? ring  : '0;
    r.flag_bits  = (st == psp_pkg::ST_OK) ? flags : '0;
    r.mem_id     = (st == psp_pkg::ST_OK) ? memid : '0;
    r.consumed   = 8'(n);
    decoded_q.push_back(r);
  endfunction

  // Saturating decimal accumulate
  function automatic void add_digit(input int d);
    if (accum > int'(psp_pkg::ACC_MUL_LIM)) accum = int'(psp_pkg::ACC_CAP);
    else accum = accum * 10 + d;
    if (accum > int'(psp_pkg::ACC_CAP)) accum = int'(psp_pkg::ACC_CAP);
  endfunction

  // Range-check the gathered number and store it as ring or memory id
  function automatic psp_pkg::status_t close_number();
    int v;
    v         = accum;
    in_number = 1'b0;
    accum     = 0;
    if (phase == PH_RING_NUM) begin
      if (v >= RING_LIMIT) return psp_pkg::ST_RING_RANGE;
      ring = 12'(v);
    end else begin
      if (v == 0 || v > 65535) return psp_pkg::ST_BAD_MEMID;
      if (memid != 0 && int'(memid) != v) return psp_pkg::ST_MEMID_CONF;
      memid = 16'(v);
    end
    phase = PH_SFX_OK;
    return psp_pkg::ST_OK;
  endfunction

  // One accepted character or end mark
  function automatic void decode_char(input logic [7:0] c, input logic endm);
    bit               dig;
    int               d;
    psp_pkg::status_t st;
    dig = (c >= CH_ZERO && c <= CH_NINE);
    d   = int'(c) - int'(CH_ZERO);

    if (stopped) begin
      if (endm) restart_string();
      return;
    end
    if (phase == PH_START) memid = preset;

    if (endm) begin
      st = psp_pkg::ST_OK;
      if (in_number) st = close_number();
      if (st == psp_pkg::ST_OK) begin
        if (phase == PH_MEMID) st = psp_pkg::ST_EMPTY_MEM;
        else if (phase == PH_RING_NUM || phase == PH_FLAG_LIST)
          st = psp_pkg::ST_EARLY_END;
      end
      report(st, nchars);
      restart_string();
      return;
    end

    // A digit run ends here; the terminating character is handled below
    if (in_number) begin
      if (dig) begin
        add_digit(d);
        count_char();
        return;
      end
      st = close_number();
      if (st != psp_pkg::ST_OK) begin
        stopped = 1'b1;
        report(st, nchars);
        return;
      end
    end

    if (phase == PH_SW_RING) begin
      if (dig) begin
        mode  = psp_pkg::MODE_ONE_SW;
        phase = PH_RING_NUM;
      end else begin
        phase = PH_SFX_OK;
      end
    end

    case (phase)
      PH_START: begin
        if (c == CH_CARET) begin
          mode  = psp_pkg::MODE_SW;
          phase = PH_SW_RING;
        end else if (c == CH_STAR) begin
          mode  = psp_pkg::MODE_NIC_SW;
          phase = PH_SFX_OK;
        end else if (c == CH_DASH) begin
          mode  = psp_pkg::MODE_ONE_NIC;
          phase = PH_RING_NUM;
        end else if (c == CH_SLASH) begin
          phase = PH_FLAG_LIST;
        end else if (c == CH_AT) begin
          phase = PH_MEMID;
        end else begin
          stopped = 1'b1;
          report(psp_pkg::ST_BAD_MOD, nchars);
          return;
        end
        count_char();
      end
      PH_SFX_OK: begin
        if (c == CH_SLASH) phase = PH_FLAG_LIST;
        else if (c == CH_AT) phase = PH_MEMID;
        else begin
          stopped = 1'b1;
          report(psp_pkg::ST_UNEXP_CHR, nchars);
          return;
        end
        count_char();
      end
      PH_RING_NUM: begin
        if (!dig) begin
          stopped = 1'b1;
          report(psp_pkg::ST_NO_NUMBER, nchars);
          return;
        end
        accum     = d;
        in_number = 1'b1;
        count_char();
      end
      PH_FLAG_LIST, PH_FLAG_OK: begin
        if (c == CH_AT) begin
          phase = PH_MEMID;
          count_char();
          return;
        end
        case (c)
          CH_X:    flags |= 6'd1;
          CH_Z:    flags |= 6'd2;
          CH_T:    flags |= 6'd4;
          CH_R:    flags |= 6'd8;
          CH_UP_R: flags |= 6'd16;
          CH_UP_T: flags |= 6'd32;
          default: begin
            stopped = 1'b1;
            report(psp_pkg::ST_BAD_FLAG, nchars);
            return;
          end
        endcase
        phase = PH_FLAG_OK;
        count_char();
      end
      PH_MEMID: begin
        // non-digit after '@': escape to options, count stops at the '@'
        if (!dig) begin
          stopped = 1'b1;
          report(psp_pkg::ST_OK, (nchars > 0) ? nchars - 1 : 0);
          return;
        end
        accum     = d;
        in_number = 1'b1;
        count_char();
      end
      default: begin
        stopped = 1'b1;
        report(psp_pkg::ST_UNEXP_CHR, nchars);
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Sample both channels at the edge where a transfer happens
  always @(posedge clk) begin
    psp_pkg::res_t want;
    if (!rst_n) begin
      restart_string();
      preset     = '0;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d consumed %0d",
                   $time, out_status, out_consumed);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("reg_mode", want.reg_mode, out_reg_mode);
          compare_field("ring_index", want.ring_index, out_ring_index);
          compare_field("flag_bits", want.flag_bits, out_flag_bits);
          compare_field("mem_id", want.mem_id, out_mem_id);
          compare_field("consumed", want.consumed, out_consumed);
        end
      end
      if (cfg_we) preset = cfg_preset_mem_id;
      if (in_push && !in_full) decode_char(in_ch, in_end_mark);
    end
    pending_results = decoded_q.size();
  end

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LIMIT   = 4095;
  localparam int MAX_CONSUMED = 255;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SEG_ITEMS    = 110;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        cfg_we            = 1'b0;
  logic [15:0] cfg_preset_mem_id = '0;
  logic        in_push           = 1'b0;
  logic        in_full;
  logic [7:0]  in_ch             = '0;
  logic        in_end_mark       = 1'b0;
  logic        out_empty;
  logic        out_pop           = 1'b0;
  logic [3:0]  out_status;
  logic [2:0]  out_reg_mode;
  logic [11:0] out_ring_index;
  logic [5:0]  out_flag_bits;
  logic [15:0] out_mem_id;
  logic [7:0]  out_consumed;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          sent_items  = 0;
  bit          tx_idle     = 1'b0;
  bit          rx_idle     = 1'b0;
  logic [15:0] cur_preset  = '0;
  logic [7:0]  chars_q[$];

  // Short suffixes covering every modifier, flag and error code
  string directed_suffixes[$] = '{
    "", "^", "^7", "*", "-0", "-4094", "-4095", "-", "-x", "/xztrRT", "/", "/q",
    "@", "@0", "@65535", "@65536", "@999999999", "@5@6", "@a", "^/x@12",
    "q^*", "*x", "-12/T@7z", "-5@x", "^12/R@40000", "^3*"
  };
  string preset_suffixes[$] = '{"", "@65535", "@3", "/x", "@a", "-7"};

  port_register_suffix_parser_unit #(
    .RING_LIMIT  (RING_LIMIT),
    .MAX_CONSUMED(MAX_CONSUMED)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_preset_mem_id(cfg_preset_mem_id),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_mark      (in_end_mark),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_reg_mode     (out_reg_mode),
    .out_ring_index   (out_ring_index),
    .out_flag_bits    (out_flag_bits),
    .out_mem_id       (out_mem_id),
    .out_consumed     (out_consumed)
  );

  psp_checker #(
    .RING_LIMIT  (RING_LIMIT),
    .MAX_CONSUMED(MAX_CONSUMED)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_preset_mem_id(cfg_preset_mem_id),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_end_mark      (in_end_mark),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_reg_mode     (out_reg_mode),
    .out_ring_index   (out_ring_index),
    .out_flag_bits    (out_flag_bits),
    .out_mem_id       (out_mem_id),
    .out_consumed     (out_consumed),
    .fail_count       (fail_count),
    .pending_results  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: pop with random stall bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_pop <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 11);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // One character transfer, optionally after an idle burst
  task automatic send_char(input logic [7:0] c, input logic endm);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push     <= 1'b1;
    in_ch       <= c;
    in_end_mark <= endm;
    do @(posedge clk); while (in_full);
    sent_items++;
  endtask

  // Send the built suffix and close it with an end mark
  task automatic send_suffix();
    foreach (chars_q[i]) send_char(chars_q[i], 1'b0);
    send_char(8'($urandom), 1'b1);
    chars_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) chars_q.push_back(s[i]);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_preset(input logic [15:0] v);
    wait_drained();
    cfg_we            <= 1'b1;
    cfg_preset_mem_id <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_preset = v;
  endtask

  function automatic string number_text(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic int unsigned pick_ring();
    case ($urandom_range(0, 11))
      0:       return 4094;
      1:       return 4095;
      2:       return 4096 + $urandom_range(0, 100000);
      3:       return $urandom;
      4:       return 0;
      default: return $urandom_range(0, 4094);
    endcase
  endfunction

  function automatic int unsigned pick_memid();
    if (cur_preset != 0 && $urandom_range(0, 2) == 0) return cur_preset;
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 65535;
      2:       return 65536 + $urandom_range(0, 100000);
      3:       return $urandom;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  // Mostly well-formed suffixes with random content, some noise and mutations
  task automatic build_random_suffix();
    int         shape;
    int         idx;
    logic [7:0] e;
    string      flag_set;
    flag_set = "xztrRT";
    shape    = $urandom_range(0, 99);
    if (shape < 12) begin
      repeat ($urandom_range(0, 8)) chars_q.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 5))
      1:       add_text("^");
      2:       add_text({"^", number_text(pick_ring())});
      3:       add_text("*");
      4, 5:    add_text({"-", number_text(pick_ring())});
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      add_text("/");
      repeat ($urandom_range(0, 6)) chars_q.push_back(flag_set[$urandom_range(0, 5)]);
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 4) == 0) begin
        // escape to options: non-digit right after '@', then option text
        add_text("@");
        do e = 8'($urandom); while (e >= "0" && e <= "9");
        chars_q.push_back(e);
        repeat ($urandom_range(0, 4)) chars_q.push_back(8'($urandom));
      end else begin
        add_text({"@", number_text(pick_memid())});
      end
    end
    if (shape < 30 && chars_q.size() > 0) begin
      idx = $urandom_range(0, chars_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       chars_q[idx] = 8'($urandom);
        1:       while (chars_q.size() > idx) void'(chars_q.pop_back());
        default: chars_q.insert(idx, 8'($urandom));
      endcase
    end
  endtask

  // Stimulus and verdict
  initial begin
    int  goal;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset preset, with idling on both sides
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (directed_suffixes[i]) begin
      add_text(directed_suffixes[i]);
      send_suffix();
    end
    // Consumed count saturation: long flag list, long zero-padded ring number
    add_text("/");
    repeat (258) add_text("x");
    send_suffix();
    add_text("-");
    repeat (258) add_text("0");
    add_text("x");
    send_suffix();

    // Highest preset id
    write_preset(16'hFFFF);
    foreach (preset_suffixes[i]) begin
      add_text(preset_suffixes[i]);
      send_suffix();
    end

    // Random segments, each with its own preset; the second and the last have no idling
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0:       write_preset(16'($urandom_range(1, 65534)));
        1:       write_preset(16'd0);
        2:       write_preset(16'd1);
        default: write_preset(16'hFFFF);
      endcase
      tx_idle = (seg % 2 == 0);
      rx_idle = (seg % 2 == 0);
      goal    = sent_items + SEG_ITEMS;
      while (sent_items < goal) begin
        build_random_suffix();
        send_suffix();
        if (seg == 2 && !paused && sent_items > goal - SEG_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
